[rtl/hes_pkg.sv]
// Shared types, constants and fixed-point helpers for the heading-error steering controller.
// No dependencies; every other file in rtl/ imports this package.
package hes_pkg;

    // Default build parameters
    localparam int HES_CORDIC_STAGES   = 16;
    localparam int HES_ANGLE_FRAC_BITS = 13;

    // Fixed field widths
    localparam int POS_W      = 32;   // Q16.16 coordinates
    localparam int POS_DIFF_W = 33;   // exact difference of two coordinates
    localparam int CORDIC_XY_W = 36;  // room for CORDIC gain on a 33-bit vector
    localparam int HEADING_W  = 16;
    localparam int CMD_W      = 16;
    localparam int GAIN_W     = 12;
    localparam int LIMIT_W    = 15;
    localparam int GAIN_FRAC  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT = 2'd1;
    localparam logic [GAIN_W-1:0]    STEER_GAIN_RESET = 12'd256;
    localparam logic [LIMIT_W-1:0]   TURN_LIMIT_RESET = 15'd8192;

    // Angle constants in Q30, rounded to the angle format at elaboration
    localparam longint Q30_PI   = 64'sd3373259426;
    localparam longint Q30_PI_4 = 64'sd843314857;
    localparam int     ATAN_ENTRIES = 24;

    // atan(2^-i) in Q30, truncated
    localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // Round a Q30 angle half-up to frac fractional bits
    function automatic longint q30_to_angle(input longint q, input int frac);
        return (q + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
    endfunction

    // Side information carried alongside the CORDIC datapath
    typedef struct packed {
        logic                        zero;     // target equals position
        logic signed [HEADING_W-1:0] heading;
    } t_tag;

endpackage

[rtl/hes_if.sv]
// Valid/ready channel interfaces: input item, result item and configuration write.
// Depends on hes_pkg for field widths.
interface hes_item_if import hes_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  target_x;
    logic signed [POS_W-1:0]  target_y;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEADING_W-1:0] heading;

    modport source (output valid, target_x, target_y, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, target_x, target_y, pos_x, pos_y, heading, output ready);
endinterface

interface hes_result_if import hes_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] turn_command;
    logic                    limited;

    modport source (output valid, turn_command, limited, input ready);
    modport sink   (input valid, turn_command, limited, output ready);
endinterface

interface hes_cfg_if import hes_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/hes_cordic.sv]
// Pipelined CORDIC atan2 in vectoring mode: half-plane pre-rotation, then one stage per iteration.
// Depends on hes_pkg for widths, the arctangent table and the angle rounding function.
module hes_cordic import hes_pkg::*; #(
    parameter int STAGES = HES_CORDIC_STAGES,
    parameter int FRAC   = HES_ANGLE_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [POS_DIFF_W-1:0] i_dx,
    input  logic signed [POS_DIFF_W-1:0] i_dy,
    input  t_tag                         i_tag,
    output logic                         o_valid,
    output logic signed [FRAC+3:0]       o_z,
    output t_tag                         o_tag
);
    localparam int     XW   = CORDIC_XY_W;
    localparam int     ZW   = FRAC + 4;
    localparam longint PI_A = q30_to_angle(Q30_PI, FRAC);

    logic               r_v   [STAGES+1];
    logic signed [XW-1:0] r_x [STAGES+1];
    logic signed [XW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES+1];
    t_tag               r_tag [STAGES+1];

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;

    assign w_dx = XW'(i_dx);
    assign w_dy = XW'(i_dy);

    // Pre-rotation: fold the left half-plane onto the right one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            if (i_dx < 0) begin
                r_x[0] <= -w_dx;
                r_y[0] <= -w_dy;
                r_z[0] <= (i_dy >= 0) ? ZW'(PI_A) : ZW'(-PI_A);
            end else begin
                r_x[0] <= w_dx;
                r_y[0] <= w_dy;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam longint ATAN_A = q30_to_angle(ATAN_Q30[i], FRAC);
        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;

        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        // Rotate towards the x axis, steering by the sign of y
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[i+1] <= r_tag[i];
                if (!r_y[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + ZW'(ATAN_A);
                end else begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - ZW'(ATAN_A);
                end
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_z     = r_z[STAGES];
    assign o_tag   = r_tag[STAGES];

endmodule

[rtl/heading_error_steering_controller.sv]
// Heading-error steering controller: bearing by pipelined CORDIC, error wrap, P gain and limit.
// Depends on hes_pkg, the channel interfaces in hes_if.sv and hes_cordic.
//
// One item enters per clock while the pipeline advances; its result passes, in order, through
// the registers for difference, pre-rotation, one stage per CORDIC iteration,
// heading subtraction, angle wrap, gain multiply and the saturating output register. The
// whole pipeline advances together; it holds only while the output register carries a beat
// that the sink has not taken. Configuration writes are accepted in every cycle and should be
// made while no item is in flight. When the wrapped error exceeds pi/4 in magnitude the
// command is the negated turn limit and limited is set; otherwise it is gain times error,
// floored and saturated to 16 bits.
module heading_error_steering_controller import hes_pkg::*; #(
    parameter int CORDIC_STAGES   = HES_CORDIC_STAGES,
    parameter int ANGLE_FRAC_BITS = HES_ANGLE_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hes_item_if.sink     i_item,
    hes_cfg_if.sink      i_cfg,
    hes_result_if.source o_result
);
    localparam int     F       = ANGLE_FRAC_BITS;
    localparam int     ZW      = F + 4;
    localparam int     EW      = ((ZW > HEADING_W) ? ZW : HEADING_W) + 1;
    localparam int     RW      = F + 3;
    localparam int     VW      = EW + 2;
    localparam int     PW      = RW + GAIN_W + 1;
    localparam int     SW      = PW - GAIN_FRAC;
    localparam longint PI_A    = q30_to_angle(Q30_PI, F);
    localparam longint QUARTER = q30_to_angle(Q30_PI_4, F);
    localparam longint TWO_PI  = 2 * PI_A;
    localparam int     WRAP_S  = $clog2(((64'sd1 <<< (EW - 1)) + TWO_PI - 1) / TWO_PI);
    localparam int     WRAP_STEPS = WRAP_S + 2;
    // Bias that makes the error non-negative and puts (-pi, pi] at [0, 2pi)
    localparam longint WRAP_OFS = PI_A - 1 + (TWO_PI <<< WRAP_S);

    // Configuration registers
    logic [GAIN_W-1:0]  r_steer_gain;
    logic [LIMIT_W-1:0] r_turn_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_gain <= STEER_GAIN_RESET;
            r_turn_limit <= TURN_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STEER_GAIN: r_steer_gain <= i_cfg.data[GAIN_W-1:0];
                CFG_TURN_LIMIT: r_turn_limit <= i_cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: move unless the output beat is waiting
    logic w_en;
    logic r_o_valid;

    assign w_en         = !r_o_valid || o_result.ready;
    assign i_item.ready = w_en;

    // Stage 1: position differences
    logic                         r1_valid;
    logic signed [POS_DIFF_W-1:0] r1_dx;
    logic signed [POS_DIFF_W-1:0] r1_dy;
    t_tag                         r1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= POS_DIFF_W'(i_item.target_x) - POS_DIFF_W'(i_item.pos_x);
            r1_dy <= POS_DIFF_W'(i_item.target_y) - POS_DIFF_W'(i_item.pos_y);
            r1_tag.zero    <= (i_item.target_x == i_item.pos_x)
                           && (i_item.target_y == i_item.pos_y);
            r1_tag.heading <= i_item.heading;
        end
    end

    // Bearing
    logic                 w_c_valid;
    logic signed [ZW-1:0] w_c_z;
    t_tag                 w_c_tag;

    hes_cordic #(
        .STAGES (CORDIC_STAGES),
        .FRAC   (F)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_valid),
        .i_dx    (r1_dx),
        .i_dy    (r1_dy),
        .i_tag   (r1_tag),
        .o_valid (w_c_valid),
        .o_z     (w_c_z),
        .o_tag   (w_c_tag)
    );

    // Stage E: heading error, biased for the wrap
    logic                 r_e_valid;
    logic [VW-1:0]        r_e_bias;
    logic signed [ZW-1:0] w_bearing;
    logic signed [EW-1:0] w_err;

    assign w_bearing = w_c_tag.zero ? '0 : w_c_z;
    assign w_err     = EW'(w_bearing) - EW'(w_c_tag.heading);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= w_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_bias <= VW'(w_err) + VW'(WRAP_OFS);
        end
    end

    // Stage W: reduce modulo 2pi by restoring steps, then remove the bias
    logic                 r_w_valid;
    logic signed [RW-1:0] r_w_err;
    logic signed [RW-1:0] n_w_err;

    always_comb begin
        logic [VW-1:0] v_rem;
        v_rem = r_e_bias;
        for (int j = WRAP_STEPS - 1; j >= 0; j--) begin
            if (v_rem >= VW'(TWO_PI <<< j)) begin
                v_rem = v_rem - VW'(TWO_PI <<< j);
            end
        end
        n_w_err = RW'(v_rem) - RW'(PI_A - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (w_en) begin
            r_w_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w_err <= n_w_err;
        end
    end

    // Stage M: limit decision and gain product
    logic                 r_m_valid;
    logic                 r_m_lim;
    logic signed [PW-1:0] r_m_prod;
    logic signed [PW-1:0] n_m_prod;

    assign n_m_prod = $signed({1'b0, r_steer_gain}) * r_w_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= r_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_prod <= n_m_prod;
            r_m_lim  <= (r_w_err > RW'(QUARTER)) || (r_w_err < RW'(-QUARTER));
        end
    end

    // Output register: floor by the gain's fraction, saturate or apply the limit
    logic signed [CMD_W-1:0] r_o_cmd;
    logic                    r_o_lim;
    logic signed [CMD_W-1:0] n_o_cmd;
    logic signed [SW-1:0]    w_scaled;

    assign w_scaled = r_m_prod[PW-1:GAIN_FRAC];

    always_comb begin
        if (r_m_lim) begin
            n_o_cmd = CMD_W'(-$signed({1'b0, r_turn_limit}));
        end else if (w_scaled > SW'(32767)) begin
            n_o_cmd = 16'sh7FFF;
        end else if (w_scaled < SW'(-32768)) begin
            n_o_cmd = 16'sh8000;
        end else begin
            n_o_cmd = w_scaled[CMD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_cmd <= n_o_cmd;
            r_o_lim <= r_m_lim;
        end
    end

    assign o_result.valid        = r_o_valid;
    assign o_result.turn_command = r_o_cmd;
    assign o_result.limited      = r_o_lim;

    // The wrapped error lies in (-pi, pi]
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_valid |-> (r_w_err <= RW'(PI_A)) && (r_w_err > RW'(-PI_A)))
        else $error("wrapped heading error out of range");

    // A limited command never turns positive
    a_limit_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_lim) |-> (r_o_cmd[CMD_W-1] || (r_o_cmd == '0)))
        else $error("limited turn command is positive");

    // Input is held off only by a waiting output beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_o_valid && !o_result.ready))
        else $error("input stalled without a waiting result");

    // A result only leaves when the sink takes it
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_o_valid) |-> $past(o_result.ready))
        else $error("result dropped without being taken");

endmodule
